FILE: rtl/sifr_pkg.sv
`timescale 1ns / 1ps

package sifr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned EV_W   = 2;
    localparam int unsigned CNT_W  = 3;

    // result kinds
    localparam logic [EV_W-1:0] EV_WRITE     = 2'd0;
    localparam logic [EV_W-1:0] EV_ACCEPT    = 2'd1;
    localparam logic [EV_W-1:0] EV_BAD_MAGIC = 2'd2;

    // parser phase
    localparam logic PH_HEADER  = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    // header byte positions
    localparam logic [CNT_W-1:0] HDR_LAST = 3'd7;

    // configuration register indexes
    localparam logic CFG_EXPECTED_MAGIC = 1'b0;
    localparam logic CFG_LOAD_BASE      = 1'b1;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [WORD_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_result;

endpackage

FILE: rtl/sifr_parse.sv
`timescale 1ns / 1ps

module sifr_parse
    import sifr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [WORD_W-1:0] i_expected_magic,
    input  logic [WORD_W-1:0] i_load_base,
    output logic              o_push,
    output t_result           o_res
);

    logic              r_phase;
    logic [CNT_W-1:0]  r_hdr_cnt;
    logic [WORD_W-1:0] r_magic;
    logic [WORD_W-1:0] r_length;
    logic [WORD_W-1:0] r_left;
    logic [WORD_W-1:0] r_offset;

    logic              n_phase;
    logic [CNT_W-1:0]  n_hdr_cnt;
    logic [WORD_W-1:0] n_magic;
    logic [WORD_W-1:0] n_length;
    logic [WORD_W-1:0] n_left;
    logic [WORD_W-1:0] n_offset;

    logic              fin;
    logic [WORD_W-1:0] len_full;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_magic   = r_magic;
        n_length  = r_length;
        n_left    = r_left;
        n_offset  = r_offset;
        o_push    = 1'b0;
        o_res     = '0;
        fin       = (r_left <= WORD_W'(1));
        len_full  = {i_byte, r_length[WORD_W-1:BYTE_W]};

        if (i_accept) begin
            if (r_phase == PH_PAYLOAD) begin
                o_push     = 1'b1;
                o_res.ev   = EV_WRITE;
                o_res.addr = i_load_base + r_offset;
                o_res.data = i_byte;
                o_res.last = fin;
                if (fin) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = '0;
                    n_magic   = '0;
                    n_length  = '0;
                    n_left    = '0;
                    n_offset  = '0;
                end else begin
                    n_left   = r_left - WORD_W'(1);
                    n_offset = r_offset + WORD_W'(1);
                end
            end else begin
                if (!r_hdr_cnt[CNT_W-1]) begin
                    n_magic = {i_byte, r_magic[WORD_W-1:BYTE_W]};
                end else begin
                    n_length = len_full;
                end
                if (r_hdr_cnt != HDR_LAST) begin
                    n_hdr_cnt = r_hdr_cnt + CNT_W'(1);
                end else begin
                    o_push    = 1'b1;
                    n_hdr_cnt = '0;
                    n_magic   = '0;
                    n_length  = '0;
                    n_left    = '0;
                    n_offset  = '0;
                    if (r_magic != i_expected_magic) begin
                        o_res.ev    = EV_BAD_MAGIC;
                        o_res.value = r_magic;
                    end else begin
                        o_res.ev    = EV_ACCEPT;
                        o_res.value = len_full;
                        o_res.last  = (len_full == '0);
                        if (len_full != '0) begin
                            n_phase = PH_PAYLOAD;
                            n_left  = len_full;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_magic   <= '0;
            r_length  <= '0;
            r_left    <= '0;
            r_offset  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_magic   <= n_magic;
            r_length  <= n_length;
            r_left    <= n_left;
            r_offset  <= n_offset;
        end
    end

    a_bad_magic_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.ev == EV_BAD_MAGIC) |=> (r_phase == PH_HEADER && r_hdr_cnt == '0))
        else $error("bad magic did not restart header");

    a_last_ends_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.last) |=> (r_phase == PH_HEADER))
        else $error("load still open after last result");

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

endmodule

FILE: rtl/sifr_outbuf.sv
`timescale 1ns / 1ps

module sifr_outbuf
    import sifr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result    r_buf [2];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_buf[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output buffer overfilled");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop did not drain buffer");

    a_ptrs_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_rd_ptr == r_wr_ptr))
        else $error("buffer pointers out of step");

endmodule

FILE: rtl/serial_image_frame_receiver.sv
`timescale 1ns / 1ps

// channel   dir  handshake                  payload
// s (rx)    in   i_s_tvalid / o_s_tready    i_s_tdata = rx_byte
// m (res)   out  o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser = event_res, o_m_tlast = last
// cfg       in   i_cfg_we (no wait)         i_cfg_index, i_cfg_wdata
//
// one byte per cycle while o_s_tready is high: the parser state updates at the transfer
// and the result is written into a two-entry output buffer, visible the following cycle
// o_s_tready drops only while both output entries are full
// synchronous active-low reset clears parser state, buffer and both registers

module serial_image_frame_receiver
    import sifr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [71:0]           o_m_tdata,   // [31:0] write_address, [39:32] write_data,
                                               // [71:40] reported_value
    output logic [EV_W-1:0]       o_m_tuser,   // [1:0] event_res
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_wdata
);

    logic [WORD_W-1:0] r_expected_magic;
    logic [WORD_W-1:0] r_load_base;
    logic              accept;
    logic              push;
    logic              room;
    t_result           res_in;
    t_result           res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= '0;
            r_load_base      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_MAGIC: r_expected_magic <= i_cfg_wdata;
                CFG_LOAD_BASE:      r_load_base      <= i_cfg_wdata;
            endcase
        end
    end

    assign o_s_tready = room;
    assign accept     = i_s_tvalid && room;

    sifr_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte           (i_s_tdata),
        .i_expected_magic (r_expected_magic),
        .i_load_base      (r_load_base),
        .o_push           (push),
        .o_res            (res_in)
    );

    sifr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res_out)
    );

    assign o_m_tdata = {res_out.value, res_out.data, res_out.addr};
    assign o_m_tuser = res_out.ev;
    assign o_m_tlast = res_out.last;

endmodule

FILE: test/tb_serial_image_frame_receiver.sv
`timescale 1ns / 1ps

module tb_serial_image_frame_receiver;
    import sifr_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 64;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;   // [7:0] rx_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [71:0]           o_m_tdata;          // [31:0] write_address, [39:32] write_data,
                                               // [71:40] reported_value
    logic [EV_W-1:0]       o_m_tuser;          // [1:0] event_res
    logic                  o_m_tlast;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_index = CFG_EXPECTED_MAGIC;
    logic [WORD_W-1:0]     i_cfg_wdata = '0;

    serial_image_frame_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // bytes waiting to be sent and events the parser should emit
    logic [7:0]  rx_bytes_q[$];
    t_result     pending_events[$];

    // parser copy and register shadows
    logic              rx_phase   = PH_HEADER;
    logic [CNT_W-1:0]  hdr_idx    = '0;
    logic [WORD_W-1:0] magic_acc  = '0;
    logic [WORD_W-1:0] len_acc    = '0;
    logic [WORD_W-1:0] remaining  = '0;
    logic [WORD_W-1:0] pay_off    = '0;
    logic [WORD_W-1:0] cfg_magic  = '0;
    logic [WORD_W-1:0] cfg_base   = '0;

    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned n_accepts      = 0;
    int unsigned n_bad_magic    = 0;
    int unsigned n_writes       = 0;
    int unsigned n_cfg_writes   = 0;
    int unsigned fail_count     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned stall_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic restart_header();
        rx_phase  = PH_HEADER;
        hdr_idx   = '0;
        magic_acc = '0;
        len_acc   = '0;
        remaining = '0;
        pay_off   = '0;
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        t_result ev;
        ev = '0;
        if (rx_phase == PH_PAYLOAD) begin
            ev.ev   = EV_WRITE;
            ev.addr = cfg_base + pay_off;
            ev.data = b;
            ev.last = (remaining <= 1);
            pending_events.push_back(ev);
            n_writes++;
            if (ev.last) begin
                restart_header();
            end else begin
                remaining = remaining - 1;
                pay_off   = pay_off + 1;
            end
        end else begin
            if (hdr_idx < 4) magic_acc = {b, magic_acc[31:8]};
            else len_acc = {b, len_acc[31:8]};
            if (hdr_idx != HDR_LAST) begin
                hdr_idx = hdr_idx + CNT_W'(1);
            end else if (magic_acc != cfg_magic) begin
                ev.ev    = EV_BAD_MAGIC;
                ev.value = magic_acc;
                pending_events.push_back(ev);
                n_bad_magic++;
                restart_header();
            end else begin
                ev.ev    = EV_ACCEPT;
                ev.value = len_acc;
                ev.last  = (len_acc == 0);
                pending_events.push_back(ev);
                n_accepts++;
                restart_header();
                if (ev.value != 0) begin
                    rx_phase  = PH_PAYLOAD;
                    remaining = ev.value;
                end
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                track_rx_byte(i_s_tdata);
                bytes_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (rx_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= rx_bytes_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: ev=%0d addr=%h data=%h value=%h last=%b",
                             o_m_tuser, o_m_tdata[31:0], o_m_tdata[39:32],
                             o_m_tdata[71:40], o_m_tlast);
            end else begin
                want = pending_events.pop_front();
                if (o_m_tuser != want.ev || o_m_tdata[31:0] != want.addr
                        || o_m_tdata[39:32] != want.data || o_m_tdata[71:40] != want.value
                        || o_m_tlast != want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch exp: ev=%0d addr=%h data=%h value=%h last=%b",
                                 want.ev, want.addr, want.data, want.value, want.last);
                        $display("         got: ev=%0d addr=%h data=%h value=%h last=%b",
                                 o_m_tuser, o_m_tdata[31:0], o_m_tdata[39:32],
                                 o_m_tdata[71:40], o_m_tlast);
                    end
                end
            end
        end
    end

    // watchdog: cycles with work pending but no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (bytes_accepted == bytes_queued && pending_events.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
    endtask

    task automatic push_frame(input logic [31:0] magic, input logic [31:0] len,
                              input int unsigned n_payload);
        push_word(magic);
        push_word(len);
        repeat (n_payload) push_byte(8'($urandom));
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXPECTED_MAGIC) cfg_magic = val;
        else cfg_base = val;
        n_cfg_writes++;
    endtask

    // mix of good frames, random bad headers and near-miss magic words
    task automatic random_frames(input int unsigned n_target);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        logic [31:0] m;
        start = bytes_queued;
        while (bytes_queued - start < n_target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(99) < 85) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 48);
                push_frame(cfg_magic, len, len);
            end else if (pick < 85) begin
                m = $urandom;
                if (m == cfg_magic) m = m ^ 32'h1;
                push_frame(m, $urandom, 0);
            end else begin
                m = cfg_magic ^ (32'h1 << $urandom_range(31));
                push_frame(m, $urandom_range(0, 12), 0);
            end
        end
    endtask

    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 57;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values
        push_frame(32'h0, 32'h0, 0);
        push_frame(32'h0, 32'h2, 2);
        push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        wait_idle();

        // address wrap past the top of memory
        write_reg(CFG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFFE);
        push_frame(32'hFFFF_FFFF, 32'h3, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h5A);
        push_frame(32'h0, 32'h5, 0);

        // base change in the middle of a payload
        push_frame(32'hFFFF_FFFF, 32'h4, 2);
        wait_idle();
        write_reg(CFG_LOAD_BASE, 32'h0000_1000);
        push_byte(8'hA5);
        push_byte(8'h3C);

        // magic change in the middle of a header
        push_word(32'h1234_5678);
        push_byte(8'h01);
        wait_idle();
        write_reg(CFG_EXPECTED_MAGIC, 32'h1234_5678);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hC3);
        wait_idle();

        write_reg(CFG_EXPECTED_MAGIC, $urandom);
        write_reg(CFG_LOAD_BASE, 32'h0);
        random_frames(240);
        wait_idle();

        send_idle_pct = 57;
        recv_idle_pct = 34;
        write_reg(CFG_EXPECTED_MAGIC, 32'h0);
        write_reg(CFG_LOAD_BASE, 32'hFFFF_FFFF);
        random_frames(240);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_EXPECTED_MAGIC, $urandom);
        write_reg(CFG_LOAD_BASE, $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00));
        push_frame(cfg_magic, 32'd40, 40);
        hold_requests++;
        random_frames(240);
        wait_idle();

        // largest length: the load never completes within the run
        push_frame(cfg_magic, 32'hFFFF_FFFF, 16);
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes with %0d register writes over three handshake mixes",
                 bytes_accepted, n_cfg_writes);
        $display("saw %0d accepted headers, %0d bad magic, %0d payload writes",
                 n_accepts, n_bad_magic, n_writes);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
